### src/ukst_pkg.sv
// Shared constants, codes and types of the unordered key set table.
`timescale 1ns / 1ps

package ukst_pkg;

	// Table size and the widths that follow from it.
	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int IDX_W    = 11;

	// Operation codes.
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_ABSENT  = 2'd1;
	localparam logic [1:0] STAT_PRESENT = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	// Request from the sequencer to the key memory.
	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
	} ram_req_t;

	// Finished result offered by the sequencer to the output register.
	typedef struct packed {
		logic             valid;
		logic [1:0]       status;
		logic [IDX_W-1:0] index;
		logic [IDX_W-1:0] entries;
	} done_t;

endpackage

### src/ukst_req_if.sv
// Request channel interface: operation and key with a valid/ready handshake.
`timescale 1ns / 1ps

interface ukst_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 operation;
	logic [ukst_pkg::KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);
endinterface

### src/ukst_rsp_if.sv
// Response channel interface: status, index and entry count with a valid/ready handshake.
`timescale 1ns / 1ps

interface ukst_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [ukst_pkg::IDX_W-1:0] index;
	logic [ukst_pkg::IDX_W-1:0] entries;

	modport source (output valid, output status, output index, output entries, input ready);
	modport sink   (input valid, input status, input index, input entries, output ready);
endinterface

### src/ukst_key_ram.sv
// Key memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module ukst_key_ram (
	input  logic                       clk,
	input  ukst_pkg::ram_req_t         ram_req,
	output logic [ukst_pkg::KEY_W-1:0] rdata
);
	import ukst_pkg::*;

	logic [KEY_W-1:0] mem_q [CAPACITY];
	logic [KEY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			mem_q[ram_req.waddr] <= ram_req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_req.re) begin
			rdata_q <= mem_q[ram_req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/ukst_ctrl.sv
// Sequencer that scans the key memory through one comparator and applies each operation.
`timescale 1ns / 1ps

module ukst_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [1:0]                 operation,
	input  logic [ukst_pkg::KEY_W-1:0] key,
	output logic                       in_ready,
	output ukst_pkg::done_t            done,
	input  logic                       take,
	output ukst_pkg::ram_req_t         ram_req,
	input  logic [ukst_pkg::KEY_W-1:0] rdata
);
	import ukst_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_MOVE,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] slot_q;
	logic [CNT_W-1:0] hit_q;
	logic [CNT_W-1:0] index_q;
	logic [1:0]       status_q;
	logic             pend_s1;
	logic [CNT_W-1:0] cmp_slot_s1;
	logic [CNT_W-1:0] last_slot;
	logic             issue;
	logic             hit_now;
	logic             miss_now;
	logic             full;

	// A read is issued for every slot below the count; its data is compared in the following cycle.
	assign issue     = (state_q == ST_SCAN) && (slot_q < count_q);
	assign hit_now   = (state_q == ST_SCAN) && pend_s1 && (rdata == key_q);
	assign miss_now  = (state_q == ST_SCAN) && !pend_s1 && !issue;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign last_slot = count_q - CNT_W'(1);

	always_comb begin
		ram_req.re    = issue || (state_q == ST_FETCH);
		ram_req.raddr = (state_q == ST_FETCH) ? last_slot[ADDR_W-1:0] : slot_q[ADDR_W-1:0];
		ram_req.we    = (miss_now && (op_q == OP_INSERT) && !full) || (state_q == ST_MOVE);
		ram_req.waddr = (state_q == ST_MOVE) ? hit_q[ADDR_W-1:0] : count_q[ADDR_W-1:0];
		ram_req.wdata = (state_q == ST_MOVE) ? rdata : key_q;
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign done.valid   = (state_q == ST_DONE);
	assign done.status  = status_q;
	assign done.index   = IDX_W'(index_q);
	assign done.entries = IDX_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_LOOKUP;
			key_q       <= '0;
			count_q     <= '0;
			slot_q      <= '0;
			hit_q       <= '0;
			index_q     <= '0;
			status_q    <= STAT_DONE;
			pend_s1     <= 1'b0;
			cmp_slot_s1 <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= operation;
						key_q   <= key;
						slot_q  <= '0;
						pend_s1 <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_s1     <= issue;
					cmp_slot_s1 <= slot_q;
					if (issue) begin
						slot_q <= slot_q + CNT_W'(1);
					end
					if (hit_now) begin
						hit_q <= cmp_slot_s1;
						case (op_q)
							OP_INSERT: begin
								status_q <= STAT_PRESENT;
								index_q  <= cmp_slot_s1;
								state_q  <= ST_DONE;
							end
							OP_REMOVE: begin
								state_q <= ST_FETCH;
							end
							default: begin
								status_q <= STAT_DONE;
								index_q  <= cmp_slot_s1;
								state_q  <= ST_DONE;
							end
						endcase
					end else if (miss_now) begin
						index_q <= count_q;
						state_q <= ST_DONE;
						case (op_q)
							OP_INSERT: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									status_q <= STAT_DONE;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							default: begin
								status_q <= STAT_ABSENT;
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					count_q  <= last_slot;
					status_q <= STAT_DONE;
					index_q  <= hit_q;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The single-port sequencing never reads and writes the memory in one cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.re && ram_req.we))
		else $error("key memory read and write in the same cycle");

	// A move only ever fills a slot that is in use.
	a_move_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE) |-> (hit_q < count_q))
		else $error("remove moves into a slot outside the table");

	// The count changes only by one, and only where an insert or a remove commits.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			(($past(state_q) == ST_SCAN) && (count_q == $past(count_q) + CNT_W'(1))) ||
			(($past(state_q) == ST_MOVE) && (count_q == $past(count_q) - CNT_W'(1))))
		else $error("entry count changed unexpectedly");

endmodule

### src/unordered_key_set_table_core.sv
// Top level of the unordered key set table: sequencer, key memory and response register.
`timescale 1ns / 1ps

//  Channel | Direction | Payload                        | Transfer when
//  --------+-----------+--------------------------------+----------------------------
//  req     | in        | operation[1:0], key[31:0]      | req.valid && req.ready
//  rsp     | out       | status[1:0], index, entries    | rsp.valid && rsp.ready
//
// Each request is handled alone. The sequencer reads one stored key per cycle from the
// key memory and compares it with the request key in one shared comparator.
// A request scans the slots in order until it finds the key or passes the count; a
// successful remove then fetches the last key and moves it into the freed slot. The worst
// case is a remove that finds its key in the last slot of a full table.
// The asynchronous reset empties the table at once by clearing the entry count; the key
// memory itself is not cleared, since no slot at or above the count is ever read.
// The response sits in its own output register, so a new request is taken while an earlier
// response still waits for rsp.ready; a request finished while that register is still full
// waits in the sequencer until the register drains.

module unordered_key_set_table_core (
	input  logic clk,
	input  logic arst_n,
	ukst_req_if.sink   req,
	ukst_rsp_if.source rsp
);
	import ukst_pkg::*;

	ram_req_t         ram_req;
	logic [KEY_W-1:0] rdata;
	done_t            done;
	logic             take;
	logic             rsp_valid_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] index_q;
	logic [IDX_W-1:0] entries_q;

	// The sequencer owns the table count and all memory traffic.
	ukst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.operation (req.operation),
		.key       (req.key),
		.in_ready  (req.ready),
		.done      (done),
		.take      (take),
		.ram_req   (ram_req),
		.rdata     (rdata)
	);

	ukst_key_ram u_key_ram (
		.clk     (clk),
		.ram_req (ram_req),
		.rdata   (rdata)
	);

	// A finished result moves into the output register when it is empty or being drained.
	assign take = done.valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			status_q    <= STAT_DONE;
			index_q     <= '0;
			entries_q   <= '0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
			status_q    <= done.status;
			index_q     <= done.index;
			entries_q   <= done.entries;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = status_q;
	assign rsp.index   = index_q;
	assign rsp.entries = entries_q;

endmodule
